FILE: src/bcfc_pkg.sv
// ----------------------------------------------------------------------------
// bcfc_pkg
// Shared types and constants of the box corner frustum cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package bcfc_pkg;

  localparam int unsigned NUM_REGS    = 8;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned ADDR_W      = REG_IDX_W + 2;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned MAT_W       = 16;
  localparam int unsigned CTR_W       = 24;
  localparam int unsigned TAG_W       = 10;
  localparam int unsigned EXT_W       = 19;
  localparam int unsigned CLIP_W      = 44;
  localparam int unsigned NUM_ROWS    = 4;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned W_ROW       = 3;
  localparam int unsigned ONE_SHIFT   = 8;

  // reset matrix is identity, listed from register 7 down to register 0
  localparam logic [NUM_REGS-1:0][DATA_W-1:0] REG_RESET = {
    32'h1000_0000, 32'h0000_0000, 32'h0000_1000, 32'h0000_0000,
    32'h0000_0000, 32'h1000_0000, 32'h0000_0000, 32'h0000_1000
  };

  typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0][MAT_W-1:0] mat_t;
  typedef logic signed [CLIP_W-1:0] clip_t;
  typedef logic [NUM_CORNERS-1:0][NUM_ROWS-1:0][CLIP_W-1:0] corner_clip_t;

  typedef struct packed {
    logic             valid;
    logic             x_only;
    logic [TAG_W-1:0] tag;
  } beat_ctl_t;

endpackage

`default_nettype wire

FILE: src/bcfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcfc_cfg_regs
// APB register file holding the packed 4x4 view-projection matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module bcfc_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bcfc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bcfc_pkg::DATA_W-1:0] pwdata,
  output logic      [bcfc_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output bcfc_pkg::mat_t                   mat_o
);

  logic [bcfc_pkg::NUM_REGS-1:0][bcfc_pkg::DATA_W-1:0] regs_q;
  logic [bcfc_pkg::REG_IDX_W-1:0]                      idx;
  logic                                                wr_en;

  assign idx    = paddr[bcfc_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = regs_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= bcfc_pkg::REG_RESET;
    end else if (wr_en) begin
      regs_q[idx] <= pwdata;
    end
  end

  // row r: even register holds columns 0 and 1, odd register columns 2 and 3
  always_comb begin
    for (int r = 0; r < bcfc_pkg::NUM_ROWS; r++) begin
      mat_o[r][0] = regs_q[2*r][15:0];
      mat_o[r][1] = regs_q[2*r][31:16];
      mat_o[r][2] = regs_q[2*r+1][15:0];
      mat_o[r][3] = regs_q[2*r+1][31:16];
    end
  end

endmodule

`default_nettype wire

FILE: src/bcfc_transform.sv
// ----------------------------------------------------------------------------
// bcfc_transform
// Three-stage pipeline: matrix products, row sums at the centre, then the
// eight corner clip vectors formed by adding or subtracting extent terms.
// ----------------------------------------------------------------------------
`default_nettype none

module bcfc_transform #(
  parameter int unsigned EXTENT_X = 16,
  parameter int unsigned EXTENT_Y = 256,
  parameter int unsigned EXTENT_Z = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire bcfc_pkg::beat_ctl_t                  ctl_i,
  input  wire logic signed [bcfc_pkg::CTR_W-1:0]    center_x_i,
  input  wire logic signed [bcfc_pkg::CTR_W-1:0]    center_y_i,
  input  wire logic signed [bcfc_pkg::CTR_W-1:0]    center_z_i,
  input  wire bcfc_pkg::mat_t                       mat_i,
  output bcfc_pkg::beat_ctl_t                       ctl_o,
  output bcfc_pkg::corner_clip_t                    clip_o
);

  // half extents in Q.8: EXTENT/2 * 256
  localparam logic signed [bcfc_pkg::EXT_W-1:0] HALF_X = bcfc_pkg::EXT_W'(EXTENT_X * 128);
  localparam logic signed [bcfc_pkg::EXT_W-1:0] HALF_Y = bcfc_pkg::EXT_W'(EXTENT_Y * 128);
  localparam logic signed [bcfc_pkg::EXT_W-1:0] HALF_Z = bcfc_pkg::EXT_W'(EXTENT_Z * 128);

  typedef bcfc_pkg::clip_t axis_vec_t [bcfc_pkg::NUM_AXES];

  logic signed [bcfc_pkg::CTR_W-1:0] ctr  [bcfc_pkg::NUM_AXES];
  logic signed [bcfc_pkg::EXT_W-1:0] half [bcfc_pkg::NUM_AXES];

  axis_vec_t           cprod_d [bcfc_pkg::NUM_ROWS];
  axis_vec_t           cprod_q [bcfc_pkg::NUM_ROWS];
  axis_vec_t           eprod_d [bcfc_pkg::NUM_ROWS];
  axis_vec_t           eprod_q [bcfc_pkg::NUM_ROWS];
  axis_vec_t           eprod_b_q [bcfc_pkg::NUM_ROWS];
  bcfc_pkg::clip_t     wterm_d [bcfc_pkg::NUM_ROWS];
  bcfc_pkg::clip_t     wterm_q [bcfc_pkg::NUM_ROWS];
  bcfc_pkg::clip_t     base_d  [bcfc_pkg::NUM_ROWS];
  bcfc_pkg::clip_t     base_q  [bcfc_pkg::NUM_ROWS];
  bcfc_pkg::corner_clip_t clip_d;
  bcfc_pkg::corner_clip_t clip_q;
  bcfc_pkg::beat_ctl_t ctl_a_q, ctl_b_q, ctl_c_q;

  assign ctr[0]  = center_x_i;
  assign ctr[1]  = center_y_i;
  assign ctr[2]  = center_z_i;
  assign half[0] = HALF_X;
  assign half[1] = HALF_Y;
  assign half[2] = HALF_Z;

  // stage a: a centre product and an extent product per matrix entry and axis
  always_comb begin
    for (int r = 0; r < bcfc_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < bcfc_pkg::NUM_AXES; c++) begin
        cprod_d[r][c] = bcfc_pkg::CLIP_W'($signed(mat_i[r][c]) * ctr[c]);
        eprod_d[r][c] = bcfc_pkg::CLIP_W'($signed(mat_i[r][c]) * half[c]);
      end
      // w of the corner is 1.0 in Q.8
      wterm_d[r] = bcfc_pkg::CLIP_W'($signed(mat_i[r][bcfc_pkg::W_ROW]))
                   <<< bcfc_pkg::ONE_SHIFT;
    end
  end

  // stage b: row value at the box centre
  always_comb begin
    for (int r = 0; r < bcfc_pkg::NUM_ROWS; r++) begin
      base_d[r] = cprod_q[r][0] + cprod_q[r][1] + cprod_q[r][2] + wterm_q[r];
    end
  end

  // stage c: corner k takes the minus side on x, y, z for bits 2, 1, 0
  always_comb begin
    for (int k = 0; k < bcfc_pkg::NUM_CORNERS; k++) begin
      for (int r = 0; r < bcfc_pkg::NUM_ROWS; r++) begin
        clip_d[k][r] = base_q[r]
                     + (k[2] ? -eprod_b_q[r][0] : eprod_b_q[r][0])
                     + (k[1] ? -eprod_b_q[r][1] : eprod_b_q[r][1])
                     + (k[0] ? -eprod_b_q[r][2] : eprod_b_q[r][2]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cprod_q   <= cprod_d;
    eprod_q   <= eprod_d;
    wterm_q   <= wterm_d;
    base_q    <= base_d;
    eprod_b_q <= eprod_q;
    clip_q    <= clip_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
      ctl_c_q <= ctl_b_q;
    end
  end

  assign ctl_o  = ctl_c_q;
  assign clip_o = clip_q;

endmodule

`default_nettype wire

FILE: src/bcfc_clip_test.sv
// ----------------------------------------------------------------------------
// bcfc_clip_test
// Clip range test of the eight corners and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcfc_clip_test (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bcfc_pkg::beat_ctl_t          ctl_i,
  input  wire bcfc_pkg::corner_clip_t       clip_i,
  output logic                              valid_o,
  output logic [bcfc_pkg::TAG_W-1:0]        tag_o,
  output logic                              visible_o
);

  logic [bcfc_pkg::NUM_CORNERS-1:0] pass;
  logic                             visible_d;
  logic                             valid_q;
  logic [bcfc_pkg::TAG_W-1:0]       tag_q;
  logic                             visible_q;

  always_comb begin
    bcfc_pkg::clip_t x, y, z, w;
    for (int k = 0; k < bcfc_pkg::NUM_CORNERS; k++) begin
      x = clip_i[k][0];
      y = clip_i[k][1];
      z = clip_i[k][2];
      w = clip_i[k][3];
      pass[k] = (w > 0) && (x <= w) && (x >= -w)
             && (ctl_i.x_only || ((y <= w) && (y >= -w) && (z <= w) && (z >= -w)));
    end
  end

  assign visible_d = |pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q     <= ctl_i.tag;
    visible_q <= visible_d;
  end

  assign valid_o   = valid_q;
  assign tag_o     = tag_q;
  assign visible_o = visible_q;

endmodule

`default_nettype wire

FILE: src/box_corner_frustum_cull.sv
// ----------------------------------------------------------------------------
// box_corner_frustum_cull
// Axis-aligned box visibility test against a view-projection frustum.
// ----------------------------------------------------------------------------
// Usage:
//   An item (req_type_i, chunk_index_i, center_*_i) is taken at a rising edge
//   with start high and busy low. busy is always low, so one box can be
//   issued every cycle.
//   The result beat (chunk_tag_o, visible_o) is shown for one cycle with
//   valid_o high, after the input register, product register, centre row
//   sum, corner clip vectors and result register. Throughput is one box
//   per clock.
//   The receiver cannot stall; each result beat must be taken when shown.
//   The matrix is written over the APB port, two signed Q4.12 entries per
//   32-bit register, registers at byte address 4*i; pready is always high.
//   Reset loads the identity matrix and empties the pipeline; no clearing
//   pass is needed. Write the matrix only with no box in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module box_corner_frustum_cull #(
  parameter int unsigned EXTENT_X = 16,
  parameter int unsigned EXTENT_Y = 256,
  parameter int unsigned EXTENT_Z = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                req_type_i,
  input  wire logic        [bcfc_pkg::TAG_W-1:0]   chunk_index_i,
  input  wire logic signed [bcfc_pkg::CTR_W-1:0]   center_x_i,
  input  wire logic signed [bcfc_pkg::CTR_W-1:0]   center_y_i,
  input  wire logic signed [bcfc_pkg::CTR_W-1:0]   center_z_i,
  output logic                                     valid_o,
  output logic             [bcfc_pkg::TAG_W-1:0]   chunk_tag_o,
  output logic                                     visible_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [bcfc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic        [bcfc_pkg::DATA_W-1:0]  pwdata,
  output logic             [bcfc_pkg::DATA_W-1:0]  prdata,
  output logic                                     pready
);

  logic                              accept;
  bcfc_pkg::beat_ctl_t               in_ctl_q;
  logic signed [bcfc_pkg::CTR_W-1:0] cx_q, cy_q, cz_q;
  bcfc_pkg::mat_t                    mat;
  bcfc_pkg::beat_ctl_t               xf_ctl;
  bcfc_pkg::corner_clip_t            xf_clip;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else begin
      in_ctl_q.valid  <= accept;
      in_ctl_q.x_only <= req_type_i;
      in_ctl_q.tag    <= chunk_index_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q            <= center_x_i;
    cy_q            <= center_y_i;
    cz_q            <= center_z_i;
  end

  bcfc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mat_o   (mat)
  );

  bcfc_transform #(
    .EXTENT_X (EXTENT_X),
    .EXTENT_Y (EXTENT_Y),
    .EXTENT_Z (EXTENT_Z)
  ) u_xf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (in_ctl_q),
    .center_x_i (cx_q),
    .center_y_i (cy_q),
    .center_z_i (cz_q),
    .mat_i      (mat),
    .ctl_o      (xf_ctl),
    .clip_o     (xf_clip)
  );

  bcfc_clip_test u_test (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (xf_ctl),
    .clip_i    (xf_clip),
    .valid_o   (valid_o),
    .tag_o     (chunk_tag_o),
    .visible_o (visible_o)
  );

`ifndef ASSERT_OFF
  // every result beat comes from an earlier start, traced back through the pipeline registers
  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, 5))
    else $error("result beat without a matching start");

  // tag of a result beat is the index given with its start
  a_tag_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (chunk_tag_o == $past(chunk_index_i, 5)))
    else $error("chunk tag does not match its start");

  // a register write is read back at the same address
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> ((paddr != $past(paddr)) || (prdata == $past(pwdata))))
    else $error("register readback differs from written data");
`endif

endmodule

`default_nettype wire
